### rtl/core/radial_taper_land_mask_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the radial taper land mask core
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef RADIAL_TAPER_LAND_MASK_CORE_ASSERT_SVH
`define RADIAL_TAPER_LAND_MASK_CORE_ASSERT_SVH

// Same-cycle implication.
`define RTLM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtlm: implication check failed");

// Implication with a fixed delay in cycles.
`define RTLM_ASSERT_DLY(label, clk, rst, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("rtlm: delayed check failed");

`endif

### rtl/core/rtlm_pkg.sv
// ----------------------------------------------------------------------------
// rtlm_pkg
// Types and fixed constants of the radial taper land mask core.
// ----------------------------------------------------------------------------
package rtlm_pkg;

  localparam int COORD_W  = 10;
  localparam int NOISE_W  = 17;
  localparam int LEVEL_W  = 8;
  localparam int SIDE_W   = 11;

  // Doubled offsets from the center, their squared sum, the radicand.
  localparam int DX_W     = 11;
  localparam int SQ_W     = 2 * DX_W + 1;
  localparam int FRAC_W   = 16;
  localparam int RAD_W    = 40;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 2;

  // Span is side in Q.8, quotient is the taper fraction in Q0.16.
  localparam int SPAN_W   = SIDE_W + 8;
  localparam int QUOT_W   = 16;
  localparam int TAPER_W  = QUOT_W + 1;
  localparam int PROD_W   = NOISE_W + TAPER_W;

  localparam int SQRT_PER_STAGE = 2;
  localparam int SQRT_STAGES    = ROOT_W / SQRT_PER_STAGE;
  localparam int DIV_PER_STAGE  = 2;
  localparam int DIV_STAGES     = QUOT_W / DIV_PER_STAGE;

  // Registers from the accepting edge to the result strobe, inclusive.
  localparam int LATENCY = 2 + SQRT_STAGES + 2 + DIV_STAGES + 2;

  localparam logic [NOISE_W-1:0] ONE_Q16    = NOISE_W'(65536);
  localparam logic [LEVEL_W-1:0] LAND_LEVEL = LEVEL_W'(127);
  localparam logic [LEVEL_W-1:0] GREY_MAX   = LEVEL_W'(255);
  localparam logic [SIDE_W-1:0]  SIDE_MIN   = SIDE_W'(2);
  localparam logic [SIDE_W-1:0]  SIDE_RESET = SIDE_W'(1024);

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic [NOISE_W-1:0] noise;
  } pixel_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               is_land;
  } result_t;

endpackage

### rtl/core/radial_taper_land_mask_core.sv
// ----------------------------------------------------------------------------
// radial_taper_land_mask_core
// Radial falloff mask: grey level and land flag for one map pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive pixel (row, column, noise in Q1.16) with start high;
//   the transaction is taken at an edge where start is high and busy is low.
//   busy is high only during reset, so a pixel can enter every cycle.
//   Result channel: done is high for one cycle with result (level, is_land);
//   the receiver takes it then and cannot hold it off, so nothing stalls.
//   Configuration: side_we with side_wdata writes the map side. The value is
//   clamped to [2, MAX_SIDE] (MAX_SIDE capped at 2047) when stored. Write
//   only while no pixel is in flight.
//   Depth: 24 registers from the accepting edge to done, inclusive.
//   Throughput: one pixel per cycle outside reset, set by the pipeline stage
//   rate; the square root retires two root bits per stage over ten stages
//   and the taper divider two quotient bits per stage over eight stages.
//   Reset: clears every valid bit and done, and sets the side to 1024
//   (clamped to MAX_SIDE). Pixels in flight at reset are dropped.
// ----------------------------------------------------------------------------
module radial_taper_land_mask_core
  import rtlm_pkg::*;
#(
  parameter int MAX_SIDE = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pixel_t            pixel,
  input  logic              side_we,
  input  logic [SIDE_W-1:0] side_wdata,
  output logic              done,
  output result_t           result
);

  localparam int SIDE_TOP = (1 << SIDE_W) - 1;
  localparam int CAP_INT  = (MAX_SIDE > SIDE_TOP) ? SIDE_TOP : MAX_SIDE;
  localparam logic [SIDE_W-1:0] SIDE_CAP = CAP_INT[SIDE_W-1:0];

  typedef struct packed {
    logic [RAD_W-1:0]   rad;
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
    logic [NOISE_W-1:0] noise;
  } sqrt_stage_t;

  typedef struct packed {
    logic [SPAN_W-1:0]  rem;
    logic [QUOT_W-1:0]  quot;
    logic               sat;
    logic [NOISE_W-1:0] noise;
  } div_stage_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s);
    logic [SIDE_W-1:0] v;
    v = s;
    if (v < SIDE_MIN) v = SIDE_MIN;
    if (v > SIDE_CAP) v = SIDE_CAP;
    return v;
  endfunction

  function automatic logic [DX_W-1:0] center_dist(input logic [COORD_W-1:0] c,
                                                  input logic [SIDE_W-1:0]  s);
    logic [DX_W-1:0] twice;
    twice = {c, 1'b0};
    return (twice >= s) ? (twice - s) : (s - twice);
  endfunction

  // One restoring square root step: bring down two radicand bits.
  function automatic sqrt_stage_t sqrt_step(input sqrt_stage_t cur);
    sqrt_stage_t     nxt;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    nxt    = cur;
    rem_sh = {cur.rem[REM_W-3:0], cur.rad[RAD_W-1 -: 2]};
    trial  = {cur.root, 2'b01};
    nxt.rad = {cur.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      nxt.rem  = rem_sh - trial;
      nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = rem_sh;
      nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  // One restoring division step; remainder stays below span.
  function automatic div_stage_t div_step(input div_stage_t cur,
                                          input logic [SPAN_W-1:0] span_in);
    div_stage_t       nxt;
    logic [SPAN_W:0]  r2;
    logic [SPAN_W:0]  diff;
    nxt  = cur;
    r2   = {cur.rem, 1'b0};
    diff = r2 - {1'b0, span_in};
    if (r2 >= {1'b0, span_in}) begin
      nxt.rem  = diff[SPAN_W-1:0];
      nxt.quot = {cur.quot[QUOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = r2[SPAN_W-1:0];
      nxt.quot = {cur.quot[QUOT_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  logic [SIDE_W-1:0] side;
  logic [SPAN_W-1:0] span;
  logic              accept;

  assign busy   = rst;
  assign accept = start && !busy;
  assign span   = {side, 8'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= clamp_side(SIDE_RESET);
    end else if (side_we) begin
      side <= clamp_side(side_wdata);
    end
  end

  // Stage A: doubled center offsets, noise saturation.
  logic               a_valid;
  logic [DX_W-1:0]    a_dx;
  logic [DX_W-1:0]    a_dy;
  logic [NOISE_W-1:0] a_noise;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
    a_dx    <= center_dist(pixel.row, side);
    a_dy    <= center_dist(pixel.column, side);
    a_noise <= (pixel.noise > ONE_Q16) ? ONE_Q16 : pixel.noise;
  end

  // Stage B: squared distance, loaded as the radicand of the root pipeline.
  logic              sq_v [SQRT_STAGES+1];
  sqrt_stage_t       sq_s [SQRT_STAGES+1];
  logic [2*DX_W-1:0] dx2;
  logic [2*DX_W-1:0] dy2;
  logic [SQ_W-1:0]   sq_sum;

  assign dx2    = (2*DX_W)'(a_dx) * (2*DX_W)'(a_dx);
  assign dy2    = (2*DX_W)'(a_dy) * (2*DX_W)'(a_dy);
  assign sq_sum = {1'b0, dx2} + {1'b0, dy2};

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else begin
      sq_v[0] <= a_valid;
    end
    sq_s[0].rad   <= {{(RAD_W - SQ_W - FRAC_W){1'b0}}, sq_sum, {FRAC_W{1'b0}}};
    sq_s[0].rem   <= '0;
    sq_s[0].root  <= '0;
    sq_s[0].noise <= a_noise;
  end

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
    sqrt_stage_t nxt;

    always_comb begin
      nxt = sq_s[g];
      for (int j = 0; j < SQRT_PER_STAGE; j++) begin
        nxt = sqrt_step(nxt);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[g+1] <= 1'b0;
      end else begin
        sq_v[g+1] <= sq_v[g];
      end
      sq_s[g+1] <= nxt;
    end
  end

  // Stage T1: distance inside the span, zero taper outside the circle.
  logic               t1_valid;
  logic [SPAN_W-1:0]  t1_gap;
  logic [NOISE_W-1:0] t1_noise;
  logic [ROOT_W-1:0]  dq;

  assign dq = sq_s[SQRT_STAGES].root;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
    end else begin
      t1_valid <= sq_v[SQRT_STAGES];
    end
    if (dq >= ROOT_W'(span)) begin
      t1_gap <= '0;
    end else begin
      t1_gap <= span - dq[SPAN_W-1:0];
    end
    t1_noise <= sq_s[SQRT_STAGES].noise;
  end

  // Stage T2: triple the gap; saturate once it reaches the span.
  logic              dv_v [DIV_STAGES+1];
  div_stage_t        dv_s [DIV_STAGES+1];
  logic [SPAN_W+1:0] gap3;

  assign gap3 = {1'b0, t1_gap, 1'b0} + {2'b00, t1_gap};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else begin
      dv_v[0] <= t1_valid;
    end
    dv_s[0].sat   <= (gap3 >= {2'b00, span});
    dv_s[0].rem   <= (gap3 >= {2'b00, span}) ? '0 : gap3[SPAN_W-1:0];
    dv_s[0].quot  <= '0;
    dv_s[0].noise <= t1_noise;
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    div_stage_t nxt;

    always_comb begin
      nxt = dv_s[g];
      for (int j = 0; j < DIV_PER_STAGE; j++) begin
        nxt = div_step(nxt, span);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[g+1] <= 1'b0;
      end else begin
        dv_v[g+1] <= dv_v[g];
      end
      dv_s[g+1] <= nxt;
    end
  end

  // Stage M: noise times taper.
  logic               m_valid;
  logic [PROD_W-1:0]  m_prod;
  logic [TAPER_W-1:0] taper;

  assign taper = dv_s[DIV_STAGES].sat ? ONE_Q16 : {1'b0, dv_s[DIV_STAGES].quot};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= dv_v[DIV_STAGES];
    end
    m_prod <= PROD_W'(dv_s[DIV_STAGES].noise) * PROD_W'(taper);
  end

  // Stage O: scale by 255, keep the integer part.
  logic [PROD_W+7:0]  scaled;
  logic [PROD_W-25:0] grey;
  logic [LEVEL_W-1:0] level;

  assign scaled = {m_prod, 8'b0} - {8'b0, m_prod};
  assign grey   = scaled[PROD_W+7:32];
  assign level  = (grey > {{(PROD_W-24-LEVEL_W){1'b0}}, GREY_MAX}) ? GREY_MAX
                                                                 : grey[LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_valid;
    end
    result.level   <= level;
    result.is_land <= (level >= LAND_LEVEL);
  end

endmodule

### rtl/core/rtlm_checker.sv
// ----------------------------------------------------------------------------
// rtlm_checker
// Port-level checks of the radial taper land mask core, bound to the top.
// ----------------------------------------------------------------------------
`include "radial_taper_land_mask_core_assert.svh"

module rtlm_checker
  import rtlm_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input pixel_t            pixel,
  input logic              side_we,
  input logic [SIDE_W-1:0] side_wdata,
  input logic              done,
  input result_t           result
);

  logic accepted;
  logic side_write;

  assign accepted   = start && !busy;
  assign side_write = side_we && (side_wdata != '0 || side_wdata == '0);

  // Every transaction comes out after the fixed pipeline depth.
  `RTLM_ASSERT_DLY(a_latency, clk, rst, accepted, LATENCY, done)

  // Zero noise gives a zero level whatever the distance.
  `RTLM_ASSERT_DLY(a_zero_noise, clk, rst, accepted && pixel.noise == '0 && !side_write,
                   LATENCY, result.level == '0)

  // Land flag agrees with the level threshold.
  `RTLM_ASSERT_IMP(a_land_flag, clk, rst, done, result.is_land == (result.level >= LAND_LEVEL))

  // Reset flushes the pipeline: no strobe right after it.
  `RTLM_ASSERT_IMP(a_reset_flush, clk, 1'b0, $past(rst), !done)

endmodule

bind radial_taper_land_mask_core rtlm_checker u_rtlm_checker (.*);
